// ===== src/c2p_pkg.sv =====
`default_nettype none

package c2p_pkg;

    localparam int GUARD_BITS  = 14;
    localparam int ANG_ACC_W   = 28;
    localparam int MAG_W       = 16;
    localparam int ANG_W       = 16;
    localparam int MAG_MAX     = 46341;
    localparam int OUT_PI      = 25736;
    localparam int OUT_HALF_PI = 12868;
    localparam int ANG_ROUND   = 1024;
    localparam int ANG_SHIFT   = 11;
    localparam int SAT_BIT     = 47;
    localparam int GAIN_FRAC   = 16;
    localparam int MAG_SHIFT   = GAIN_FRAC + GUARD_BITS;

    localparam logic signed [ANG_ACC_W-1:0] ANG_PI_Q24 = 28'sd52707179;
    localparam logic [31:0] GAIN_INV_Q32 = 32'd2608131496;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic signed [ANG_ACC_W-1:0] atan_q24(input int unsigned i);
        logic signed [ANG_ACC_W-1:0] r;
        unique case (i)
            0: r = 28'sd13176795;
            1: r = 28'sd7778716;
            2: r = 28'sd4110060;
            3: r = 28'sd2086331;
            4: r = 28'sd1047214;
            5: r = 28'sd524117;
            6: r = 28'sd262123;
            7: r = 28'sd131069;
            default: r = (i > 24) ? '0 : ANG_ACC_W'(32'd1 << (24 - i));
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/c2p_point_if.sv =====
`default_nettype none

interface c2p_point_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

`default_nettype wire

// ===== src/c2p_polar_if.sv =====
`default_nettype none

interface c2p_polar_if import c2p_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [MAG_W-1:0] magnitude;
    logic signed [ANG_W-1:0] angle_rad;

    modport source (output valid, output magnitude, output angle_rad, input ready);
    modport sink   (input valid, input magnitude, input angle_rad, output ready);
endinterface

`default_nettype wire

// ===== src/cartesian_to_polar.sv =====
// Cartesian to polar converter, CORDIC vectoring pipeline.
// point: valid/ready channel carrying signed x_coord and y_coord, each
//   COORD_WIDTH bits wide; a transfer happens when valid and ready are high.
// polar: valid/ready channel carrying magnitude (unsigned, rounded,
//   saturated at 46341) and angle_rad (Q3.13 radians, -pi..pi).
// Throughput: one point per cycle unless stalled; every stage holds one item.
// Pipeline: the entry stage for sign handling and axis cases loads at the
//   transfer edge, then one stage per CORDIC micro-rotation, one stage for
//   the gain multiply and angle rounding, and one output register.
// Stall: each stage loads while it is empty or its successor loads, so
//   bubbles close up behind a stalled receiver; point.ready drops only when
//   every stage holds an item and polar.ready is low. Nothing is dropped.
// Reset: rst_n clears all valid bits at once; the pipeline is empty and
//   point.ready is high on the first cycle after reset.
`default_nettype none

module cartesian_to_polar import c2p_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    c2p_point_if.sink    point,
    c2p_polar_if.source  polar
);

    localparam int DW = COORD_WIDTH + GUARD_BITS + 3;
    localparam int NS = CORDIC_STAGES;

    // stage control
    logic [NS:0] cv_reg;
    logic [NS:0] cen;
    logic        m_valid_reg;
    logic        men;
    logic        o_valid_reg;
    logic        oen;

    // CORDIC datapath, index 0 is the entry stage
    logic signed [DW-1:0]        x_reg    [0:NS];
    logic signed [DW-1:0]        y_reg    [0:NS];
    logic signed [ANG_ACC_W-1:0] z_reg    [0:NS];
    logic                        spec_reg [0:NS];
    logic        [MAG_W-1:0]     smag_reg [0:NS];
    logic signed [ANG_W-1:0]     sang_reg [0:NS];

    logic signed [DW-1:0]        x_next   [0:NS];
    logic signed [DW-1:0]        y_next   [0:NS];
    logic signed [ANG_ACC_W-1:0] z_next   [0:NS];

    // entry stage
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [DW-1:0] xg;
    logic signed [DW-1:0] yg;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic                 x_zero;
    logic                 y_zero;
    logic                 spec_next;
    logic [MAG_W-1:0]     smag_next;
    logic signed [ANG_W-1:0] sang_next;

    // multiply stage
    logic [63:0]                  ux;
    logic [47:0]                  pl_full;
    logic signed [ANG_ACC_W:0]    zr;
    logic signed [ANG_ACC_W:0]    zq;
    logic                         m_sat_next;
    logic [62:0]                  m_ph_next;
    logic [31:0]                  m_pl_next;
    logic signed [ANG_W-1:0]      m_ang_next;
    logic                         m_sat_reg;
    logic [62:0]                  m_ph_reg;
    logic [31:0]                  m_pl_reg;
    logic signed [ANG_W-1:0]      m_ang_reg;
    logic                         m_spec_reg;
    logic [MAG_W-1:0]             m_smag_reg;
    logic signed [ANG_W-1:0]      m_sang_reg;

    // output stage
    logic [63:0]             p;
    logic [33:0]             mag_full;
    logic [MAG_W-1:0]        o_mag_next;
    logic signed [ANG_W-1:0] o_ang_next;
    logic [MAG_W-1:0]        o_mag_reg;
    logic signed [ANG_W-1:0] o_ang_reg;

    // stall chain
    assign oen = !o_valid_reg || polar.ready;
    assign men = !m_valid_reg || oen;
    assign cen[NS] = !cv_reg[NS] || men;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_en
            assign cen[k] = !cv_reg[k] || cen[k+1];
        end
    endgenerate

    assign point.ready = cen[0];

    // entry stage: sign extend, scale, fold left half plane, axis cases
    always_comb
    begin
        xs     = DW'(point.x_coord);
        ys     = DW'(point.y_coord);
        x_zero = (point.x_coord == '0);
        y_zero = (point.y_coord == '0);
        ax     = (xs < 0) ? -xs : xs;
        ay     = (ys < 0) ? -ys : ys;
        xg     = xs <<< GUARD_BITS;
        yg     = ys <<< GUARD_BITS;

        spec_next = x_zero || y_zero;
        if (y_zero)
        begin
            smag_next = (ax > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(ax);
            sang_next = (xs < 0) ? ANG_W'(OUT_PI) : '0;
        end
        else
        begin
            smag_next = (ay > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(ay);
            sang_next = (ys < 0) ? -ANG_W'(OUT_HALF_PI) : ANG_W'(OUT_HALF_PI);
        end

        if (xs < 0)
        begin
            x_next[0] = -xg;
            y_next[0] = -yg;
            z_next[0] = (ys > 0) ? ANG_PI_Q24 : -ANG_PI_Q24;
        end
        else
        begin
            x_next[0] = xg;
            y_next[0] = yg;
            z_next[0] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (cen[0])
        begin
            cv_reg[0] <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cen[0])
        begin
            x_reg[0]    <= x_next[0];
            y_reg[0]    <= y_next[0];
            z_reg[0]    <= z_next[0];
            spec_reg[0] <= spec_next;
            smag_reg[0] <= smag_next;
            sang_reg[0] <= sang_next;
        end
    end

    // micro-rotation stages, stage k applies iteration k-1
    generate
        for (k = 1; k <= NS; k++)
        begin : g_rot
            localparam int SH = k - 1;

            always_comb
            begin
                if (y_reg[k-1] >= 0)
                begin
                    x_next[k] = x_reg[k-1] + (y_reg[k-1] >>> SH);
                    y_next[k] = y_reg[k-1] - (x_reg[k-1] >>> SH);
                    z_next[k] = z_reg[k-1] + atan_q24(SH);
                end
                else
                begin
                    x_next[k] = x_reg[k-1] - (y_reg[k-1] >>> SH);
                    y_next[k] = y_reg[k-1] + (x_reg[k-1] >>> SH);
                    z_next[k] = z_reg[k-1] - atan_q24(SH);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cv_reg[k] <= 1'b0;
                end
                else if (cen[k])
                begin
                    cv_reg[k] <= cv_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (cen[k])
                begin
                    x_reg[k]    <= x_next[k];
                    y_reg[k]    <= y_next[k];
                    z_reg[k]    <= z_next[k];
                    spec_reg[k] <= spec_reg[k-1];
                    smag_reg[k] <= smag_reg[k-1];
                    sang_reg[k] <= sang_reg[k-1];
                end
            end
        end
    endgenerate

    // gain multiply split in two partial products; round and clamp angle
    always_comb
    begin
        ux         = (x_reg[NS] > 0) ? 64'(x_reg[NS]) : '0;
        m_sat_next = |ux[63:SAT_BIT];
        m_ph_next  = 63'(ux[SAT_BIT-1:GAIN_FRAC]) * 63'(GAIN_INV_Q32);
        pl_full    = 48'(ux[GAIN_FRAC-1:0]) * 48'(GAIN_INV_Q32);
        m_pl_next  = pl_full[47:GAIN_FRAC];

        zr = (ANG_ACC_W+1)'(z_reg[NS]) + (ANG_ACC_W+1)'(ANG_ROUND);
        zq = zr >>> ANG_SHIFT;
        if (zq > OUT_PI)
        begin
            m_ang_next = ANG_W'(OUT_PI);
        end
        else if (zq < -OUT_PI)
        begin
            m_ang_next = -ANG_W'(OUT_PI);
        end
        else
        begin
            m_ang_next = ANG_W'(zq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (men)
        begin
            m_valid_reg <= cv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (men)
        begin
            m_sat_reg  <= m_sat_next;
            m_ph_reg   <= m_ph_next;
            m_pl_reg   <= m_pl_next;
            m_ang_reg  <= m_ang_next;
            m_spec_reg <= spec_reg[NS];
            m_smag_reg <= smag_reg[NS];
            m_sang_reg <= sang_reg[NS];
        end
    end

    // sum partial products, round half up, saturate, pick axis results
    always_comb
    begin
        p        = 64'(m_ph_reg) + 64'(m_pl_reg) + (64'd1 << (MAG_SHIFT - 1));
        mag_full = p[63:MAG_SHIFT];
        if (m_spec_reg)
        begin
            o_mag_next = m_smag_reg;
            o_ang_next = m_sang_reg;
        end
        else
        begin
            o_mag_next = (m_sat_reg || mag_full > MAG_MAX) ? MAG_W'(MAG_MAX)
                                                           : mag_full[MAG_W-1:0];
            o_ang_next = m_ang_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (oen)
        begin
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oen)
        begin
            o_mag_reg <= o_mag_next;
            o_ang_reg <= o_ang_next;
        end
    end

    assign polar.valid     = o_valid_reg;
    assign polar.magnitude = o_mag_reg;
    assign polar.angle_rad = o_ang_reg;

`ifndef SYNTH
    a_entry_loads: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> cv_reg[0])
        else $error("accepted point did not enter the pipeline");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !point.ready |-> (&cv_reg) && m_valid_reg && o_valid_reg && !polar.ready)
        else $error("input held off while a stage is empty");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        polar.valid |-> (polar.magnitude <= MAG_MAX) && (polar.angle_rad <= OUT_PI)
                        && (polar.angle_rad >= -OUT_PI))
        else $error("result out of range");
`endif

endmodule

`default_nettype wire
